@@ rtl/prc_pkg.sv @@
// Package for the rectangular polygon clipper.
// Holds coordinate width, token and boundary types, cell states, register codes.
// No dependencies.
package prc_pkg;

  localparam int COORD_BITS = 16;
  localparam int PROD_BITS  = 2 * COORD_BITS;
  localparam int CNT_W      = $clog2(COORD_BITS);
  localparam int CFG_AW     = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam logic [CFG_AW-1:0] CFG_XMIN = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] CFG_YMIN = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] CFG_XMAX = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] CFG_YMAX = CFG_AW'(3);

  localparam coord_t XMIN_RST = coord_t'(0);
  localparam coord_t YMIN_RST = coord_t'(0);
  localparam coord_t XMAX_RST = coord_t'(1023);
  localparam coord_t YMAX_RST = coord_t'(1023);

  // point or close marker travelling down the chain
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   close;
  } tok_t;

  // boundary handled by one cell
  typedef struct packed {
    coord_t bound;
    logic   axis_x;   // compare x (else y)
    logic   keep_ge;  // inside when coord >= bound (else <=)
  } bnd_t;

  typedef enum logic [2:0] {
    C_IDLE, C_EVAL, C_MUL, C_DIV, C_RND, C_EMIT_I, C_EMIT_E, C_EMIT_C
  } cell_state_t;

endpackage

@@ rtl/prc_cell.sv @@
// One boundary cell of the clipper chain: keeps first/previous vertex,
// clips each edge and passes points and the close marker on. Uses prc_pkg.
module prc_cell import prc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  bnd_t bnd,
  input  logic up_valid,
  input  tok_t up_tok,
  output logic up_ready,
  output logic dn_valid,
  output tok_t dn_tok,
  input  logic dn_ready,
  output logic idle
);

  localparam int C = COORD_BITS;

  cell_state_t state_r, state_nxt;
  tok_t        cur_r, tok_r;
  coord_t      first_x_r, first_y_r, prev_x_r, prev_y_r, e2x_r, e2y_r, p1_r;
  logic        started_r, i2_r, cl_r, neg_r;
  logic [C-1:0] mag_r, a_r, d_r, rem_r, pl_r, q_r;
  logic [CNT_W-1:0] cnt_r;

  coord_t e2x, e2y, q1, q2, p1, p2;
  logic   i1, i2;
  logic signed [C:0] d_w, a_w, dp_w, d_abs, a_abs, dp_abs;
  logic [PROD_BITS-1:0] prod;
  logic [C:0] rem_sh, rem_sub;
  logic       ge;
  logic       up_bit;
  logic [C:0] res_w;

  always_comb begin
    e2x = cur_r.close ? first_x_r : cur_r.x;
    e2y = cur_r.close ? first_y_r : cur_r.y;
    q1  = bnd.axis_x ? prev_x_r : prev_y_r;
    q2  = bnd.axis_x ? e2x : e2y;
    p1  = bnd.axis_x ? prev_y_r : prev_x_r;
    p2  = bnd.axis_x ? e2y : e2x;
    i1  = bnd.keep_ge ? (q1 >= bnd.bound) : (q1 <= bnd.bound);
    i2  = bnd.keep_ge ? (q2 >= bnd.bound) : (q2 <= bnd.bound);
    d_w  = {q2[C-1], q2} - {q1[C-1], q1};
    a_w  = {bnd.bound[C-1], bnd.bound} - {q1[C-1], q1};
    dp_w = {p2[C-1], p2} - {p1[C-1], p1};
    d_abs  = d_w[C] ? -d_w : d_w;
    a_abs  = d_w[C] ? -a_w : a_w;
    dp_abs = dp_w[C] ? -dp_w : dp_w;
  end

  assign prod = PROD_BITS'(mag_r) * PROD_BITS'(a_r);

  // restoring division, one quotient bit a cycle
  assign rem_sh  = {rem_r, pl_r[C-1]};
  assign ge      = rem_sh >= {1'b0, d_r};
  assign rem_sub = rem_sh - {1'b0, d_r};

  // round to nearest, halves towards plus infinity
  always_comb begin
    if (neg_r) begin
      up_bit = {rem_r, 1'b0} > {1'b0, d_r};
      res_w  = {p1_r[C-1], p1_r} - {1'b0, q_r} - (C+1)'(up_bit);
    end else begin
      up_bit = {rem_r, 1'b0} >= {1'b0, d_r};
      res_w  = {p1_r[C-1], p1_r} + {1'b0, q_r} + (C+1)'(up_bit);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      C_IDLE: if (up_valid) state_nxt = C_EVAL;
      C_EVAL: begin
        if (!started_r) state_nxt = cur_r.close ? C_EMIT_C : C_IDLE;
        else if (i1 != i2) state_nxt = C_MUL;
        else if (i2) state_nxt = C_EMIT_E;
        else state_nxt = cur_r.close ? C_EMIT_C : C_IDLE;
      end
      C_MUL: state_nxt = C_DIV;
      C_DIV: if (cnt_r == CNT_W'(C-1)) state_nxt = C_RND;
      C_RND: state_nxt = C_EMIT_I;
      C_EMIT_I: if (dn_ready) begin
        if (i2_r) state_nxt = C_EMIT_E;
        else state_nxt = cl_r ? C_EMIT_C : C_IDLE;
      end
      C_EMIT_E: if (dn_ready) state_nxt = cl_r ? C_EMIT_C : C_IDLE;
      C_EMIT_C: if (dn_ready) state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    up_ready = (state_r == C_IDLE);
    idle     = (state_r == C_IDLE);
    dn_valid = (state_r == C_EMIT_I) || (state_r == C_EMIT_E) || (state_r == C_EMIT_C);
    dn_tok   = tok_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= C_IDLE;
      started_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        C_EVAL: begin
          if (cur_r.close) started_r <= 1'b0;
          else started_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      C_IDLE: if (up_valid) cur_r <= up_tok;
      C_EVAL: begin
        e2x_r <= e2x;
        e2y_r <= e2y;
        i2_r  <= i2;
        cl_r  <= cur_r.close;
        mag_r <= dp_abs[C-1:0];
        neg_r <= dp_w[C];
        d_r   <= d_abs[C-1:0];
        a_r   <= a_abs[C-1:0];
        p1_r  <= p1;
        if (!cur_r.close) begin
          prev_x_r <= cur_r.x;
          prev_y_r <= cur_r.y;
          if (!started_r) begin
            first_x_r <= cur_r.x;
            first_y_r <= cur_r.y;
          end
        end
        if (!started_r || i1 == i2) begin
          tok_r.x     <= e2x;
          tok_r.y     <= e2y;
          tok_r.close <= cur_r.close && !(started_r && i2);
        end
      end
      C_MUL: begin
        rem_r <= prod[PROD_BITS-1:C];
        pl_r  <= prod[C-1:0];
        cnt_r <= '0;
      end
      C_DIV: begin
        rem_r <= ge ? rem_sub[C-1:0] : rem_sh[C-1:0];
        pl_r  <= {pl_r[C-2:0], 1'b0};
        q_r   <= {q_r[C-2:0], ge};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      C_RND: begin
        tok_r.x     <= bnd.axis_x ? bnd.bound : coord_t'(res_w[C-1:0]);
        tok_r.y     <= bnd.axis_x ? coord_t'(res_w[C-1:0]) : bnd.bound;
        tok_r.close <= 1'b0;
      end
      C_EMIT_I: if (dn_ready) begin
        tok_r.x     <= e2x_r;
        tok_r.y     <= e2y_r;
        tok_r.close <= !i2_r;
      end
      C_EMIT_E: if (dn_ready) tok_r.close <= 1'b1;
      default: ;
    endcase
  end

endmodule

@@ rtl/prc_sink.sv @@
// Output end of the clipper: holds back one vertex to flag the polygon end,
// keeps one result in hand to flag the last of a transaction. Uses prc_pkg.
module prc_sink import prc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   tok_valid,
  input  tok_t   tok,
  output logic   tok_ready,
  input  logic   flush_ok,
  output logic   hold_valid,
  output logic   out_valid,
  input  logic   out_ready,
  output coord_t out_x,
  output coord_t out_y,
  output logic   out_run_last,
  output logic   out_polygon_end,
  output logic   out_polygon_empty
);

  logic   any_r, hold_v_r, out_v_r;
  coord_t pend_x_r, pend_y_r, hold_x_r, hold_y_r;
  logic   hold_end_r, hold_empty_r;
  coord_t ox_r, oy_r;
  logic   orl_r, oend_r, oempty_r;
  logic   out_free, tok_acc, produce, flush;

  assign out_free  = !out_v_r || out_ready;
  assign tok_ready = !hold_v_r || out_free;
  assign tok_acc   = tok_valid && tok_ready;
  assign produce   = tok_acc && (tok.close || any_r);
  assign flush     = flush_ok && hold_v_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      any_r    <= 1'b0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (tok_acc) any_r <= !tok.close;
      if (produce) hold_v_r <= 1'b1;
      else if (flush) hold_v_r <= 1'b0;
      if ((produce && hold_v_r) || flush) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_acc && !tok.close) begin
      pend_x_r <= tok.x;
      pend_y_r <= tok.y;
    end
    if (produce) begin
      hold_x_r     <= any_r ? pend_x_r : '0;
      hold_y_r     <= any_r ? pend_y_r : '0;
      hold_end_r   <= tok.close;
      hold_empty_r <= tok.close && !any_r;
    end
    if ((produce && hold_v_r) || flush) begin
      ox_r     <= hold_x_r;
      oy_r     <= hold_y_r;
      orl_r    <= !(produce && hold_v_r);
      oend_r   <= hold_end_r;
      oempty_r <= hold_empty_r;
    end
  end

  assign hold_valid        = hold_v_r;
  assign out_valid         = out_v_r;
  assign out_x             = ox_r;
  assign out_y             = oy_r;
  assign out_run_last      = orl_r;
  assign out_polygon_end   = oend_r;
  assign out_polygon_empty = oempty_r;

endmodule

@@ rtl/polygon_rect_clipper_unit.sv @@
// Top level: window registers, vertex feeder, four boundary cells, output end.
// Timing: a vertex passed on without a crossing goes through each cell's evaluate and emit
//   steps; a crossing adds multiply, serial divide, round, emit; results leave via hold/out regs.
// Throughput: one transaction at a time; a new vertex is taken only once the chain has drained,
//   which takes longer when many intersections are cut (serial divider in each cell).
// Reset (rst_n, synchronous): window 0,0,1023,1023, all cells empty, no output.
// Depends on prc_pkg, prc_cell, prc_sink.
module polygon_rect_clipper_unit import prc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  coord_t            cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  coord_t            in_vert_x,
  input  coord_t            in_vert_y,
  input  logic              in_vert_last,
  output logic              out_valid,
  input  logic              out_ready,
  output coord_t            out_x,
  output coord_t            out_y,
  output logic              out_run_last,
  output logic              out_polygon_end,
  output logic              out_polygon_empty
);

  coord_t xmin_r, ymin_r, xmax_r, ymax_r;
  logic   busy_r, feed_pt_r, feed_cl_r;
  coord_t fx_r, fy_r;

  bnd_t bnd [4];
  logic v   [5];
  logic rdy [5];
  tok_t tk  [5];
  logic cidle [4];
  logic chain_idle, hold_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xmin_r <= XMIN_RST;
      ymin_r <= YMIN_RST;
      xmax_r <= XMAX_RST;
      ymax_r <= YMAX_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_XMIN: xmin_r <= cfg_wdata;
        CFG_YMIN: ymin_r <= cfg_wdata;
        CFG_XMAX: xmax_r <= cfg_wdata;
        CFG_YMAX: ymax_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // left, top, right, bottom
  assign bnd[0] = '{bound: xmin_r, axis_x: 1'b1, keep_ge: 1'b1};
  assign bnd[1] = '{bound: ymax_r, axis_x: 1'b0, keep_ge: 1'b0};
  assign bnd[2] = '{bound: xmax_r, axis_x: 1'b1, keep_ge: 1'b0};
  assign bnd[3] = '{bound: ymin_r, axis_x: 1'b0, keep_ge: 1'b1};

  assign in_ready   = !busy_r;
  assign chain_idle = !feed_pt_r && !feed_cl_r && cidle[0] && cidle[1] && cidle[2] && cidle[3];

  // feeder: the vertex, then a close marker on the last one
  assign v[0]        = feed_pt_r || feed_cl_r;
  assign tk[0].x     = fx_r;
  assign tk[0].y     = fy_r;
  assign tk[0].close = !feed_pt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      feed_pt_r <= 1'b0;
      feed_cl_r <= 1'b0;
    end else begin
      if (in_valid && !busy_r) begin
        busy_r    <= 1'b1;
        feed_pt_r <= 1'b1;
        feed_cl_r <= in_vert_last;
      end else begin
        if (busy_r && chain_idle && !hold_valid) busy_r <= 1'b0;
        if (v[0] && rdy[0]) begin
          if (feed_pt_r) feed_pt_r <= 1'b0;
          else feed_cl_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !busy_r) begin
      fx_r <= in_vert_x;
      fy_r <= in_vert_y;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_cell
    prc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .bnd      (bnd[g]),
      .up_valid (v[g]),
      .up_tok   (tk[g]),
      .up_ready (rdy[g]),
      .dn_valid (v[g+1]),
      .dn_tok   (tk[g+1]),
      .dn_ready (rdy[g+1]),
      .idle     (cidle[g])
    );
  end

  prc_sink u_sink (
    .clk               (clk),
    .rst_n             (rst_n),
    .tok_valid         (v[4]),
    .tok               (tk[4]),
    .tok_ready         (rdy[4]),
    .flush_ok          (busy_r && chain_idle),
    .hold_valid        (hold_valid),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_run_last      (out_run_last),
    .out_polygon_end   (out_polygon_end),
    .out_polygon_empty (out_polygon_empty)
  );

endmodule
